// File: hw/rtl/qrs_pkg.sv
// qrs_pkg: sizes and widths shared by the quadrant reflection search block.
// Used by qrs_if.sv, quadrant_reflection_search.sv and the bench; depends on nothing.
package qrs_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_W    = 10;  // cell address into the store
  localparam int SIZE_W    = 11;  // size_used and one-based cell numbers
  localparam int DATA_W    = 32;
  localparam int BASE_W    = 6;   // side b of the square, up to 32
  localparam int HALF_W    = 5;   // quadrant side m, up to 16
  localparam int N_W       = 12;  // headroom for candidate arithmetic

  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_CELLS);

  // action codes of an input word
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

endpackage

// File: hw/rtl/qrs_if.sv
// qrs_if: valid/ready channel interfaces of the quadrant reflection search.
// Depends on qrs_pkg for payload widths.
interface qrs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [qrs_pkg::ADDR_W-1:0]          index;
  logic signed [qrs_pkg::DATA_W-1:0]   value;

  modport source (output valid, output action, output index, output value, input ready);
  modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface qrs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [qrs_pkg::SIZE_W-1:0]  cell_res;

  modport source (output valid, output found, output cell_res, input ready);
  modport sink   (input valid, input found, input cell_res, output ready);
endinterface

interface qrs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [qrs_pkg::SIZE_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/quadrant_reflection_search.sv
// quadrant_reflection_search: store of 1024 words with a mirrored quadrant search.
// Depends on qrs_pkg and the channel interfaces in qrs_if.sv.
//
// Usage:
//   in_ch  : one word per item. action 0 writes value into cell index. action 1
//            searches for value among the first size_used cells and yields one
//            word on out_ch.
//   out_ch : found and the one-based cell of the first hit (0 when none).
//   cfg_ch : writes size_used; always ready, write only while the block is idle.
// Search: a base step finds the square side b (b*b >= size), then one candidate
//   a cycle from a single adder feeds the read/compare pipe (p0, read with p1)
//   on the store's read port: 4*m*m candidates, m = (b+1)/2; a hit ends the
//   walk early. in_ch.ready is high only while idle.
// Reset: size_used returns to 1024, the store contents are undefined until
//   written, no result is pending.
// Stall: a finished result sits in the output register; the block goes back to
//   idle and takes writes meanwhile. A following search holds its result until
//   the previous word has been taken.
module quadrant_reflection_search (
  input  logic          clk,
  input  logic          rst_n,
  qrs_in_if.sink        in_ch,
  qrs_out_if.source     out_ch,
  qrs_cfg_if.sink       cfg_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_BASE, ST_WALK, ST_FIN} state_t;
  typedef enum logic [1:0] {PR_SELF, PR_ROW, PR_COL, PR_DIAG} probe_t;

  localparam int SW = qrs_pkg::SIZE_W;
  localparam int NW = qrs_pkg::N_W;
  localparam int BW = qrs_pkg::BASE_W;
  localparam int HW = qrs_pkg::HALF_W;

  state_t                        state_r, state_nxt;
  logic [SW-1:0]                 size_used_r, size_used_nxt;
  logic [SW-1:0]                 s_r, s_nxt;
  logic [qrs_pkg::DATA_W-1:0]    needle_r, needle_nxt;
  logic [BW-1:0]                 b_r, b_nxt;
  logic [NW-1:0]                 sq_r, sq_nxt;
  logic [HW-1:0]                 m_r, m_nxt;
  logic [HW-1:0]                 r_r, r_nxt;
  logic [HW-1:0]                 c_r, c_nxt;
  probe_t                        k_r, k_nxt;
  logic [NW-1:0]                 rb_r, rb_nxt;   // (r-1)*b
  logic [NW-1:0]                 cb_r, cb_nxt;   // (c-1)*b
  logic                          gen_end_r, gen_end_nxt;
  logic                          p0_v_r, p0_v_nxt;
  logic [SW-1:0]                 p0_n_r, p0_n_nxt;
  logic                          p1_v_r, p1_v_nxt;
  logic [SW-1:0]                 p1_n_r, p1_n_nxt;
  logic [SW-1:0]                 res_r, res_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [SW-1:0]                 out_cell_r, out_cell_nxt;

  logic [qrs_pkg::DATA_W-1:0]    mem [qrs_pkg::MAX_CELLS];
  logic [qrs_pkg::DATA_W-1:0]    rd_r;
  logic                          mem_we;
  logic [SW-1:0]                 p0_dec;
  logic [NW-1:0]                 cand;
  logic [NW-1:0]                 b_ext, r_ext, c_ext;
  logic [BW:0]                   b_inc;
  logic                          hit;

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.found   = out_found_r;
  assign out_ch.cell_res = out_cell_r;

  assign b_ext = NW'(b_r);
  assign r_ext = NW'(r_r);
  assign c_ext = NW'(c_r);
  assign b_inc = {1'b0, b_r} + 1'b1;
  assign hit   = p1_v_r && (rd_r == needle_r);
  assign p0_dec = p0_n_r - 1'b1;

  // shared candidate adder: one mirror per cycle
  always_comb begin
    case (k_r)
      PR_SELF: cand = rb_r + c_ext;
      PR_ROW:  cand = rb_r + b_ext + 1'b1 - c_ext;
      PR_COL:  cand = sq_r - b_ext - rb_r + c_ext;
      PR_DIAG: cand = sq_r - cb_r + 1'b1 - r_ext;
      default: cand = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    size_used_nxt = size_used_r;
    s_nxt         = s_r;
    needle_nxt    = needle_r;
    b_nxt         = b_r;
    sq_nxt        = sq_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    rb_nxt        = rb_r;
    cb_nxt        = cb_r;
    gen_end_nxt   = gen_end_r;
    p0_v_nxt      = p0_v_r;
    p0_n_nxt      = p0_n_r;
    p1_v_nxt      = p1_v_r;
    p1_n_nxt      = p1_n_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_cell_nxt  = out_cell_r;
    mem_we        = 1'b0;

    if (cfg_ch.valid) begin
      size_used_nxt = cfg_ch.data;
    end
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.action == qrs_pkg::ACT_WRITE) begin
            mem_we = 1'b1;
          end else begin
            needle_nxt = in_ch.value;
            s_nxt      = (size_used_r > qrs_pkg::SIZE_CAP) ? qrs_pkg::SIZE_CAP : size_used_r;
            b_nxt      = BW'(1);
            sq_nxt     = NW'(1);
            state_nxt  = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        p0_v_nxt = 1'b0;
        p1_v_nxt = 1'b0;
        if (NW'(s_r) > sq_r) begin
          // (b+1)^2 = b^2 + 2b + 1
          sq_nxt = sq_r + NW'({b_r, 1'b1});
          b_nxt  = b_r + 1'b1;
        end else begin
          m_nxt       = b_inc[HW:1];
          r_nxt       = HW'(1);
          c_nxt       = HW'(1);
          k_nxt       = PR_SELF;
          rb_nxt      = '0;
          cb_nxt      = '0;
          gen_end_nxt = 1'b0;
          state_nxt   = ST_WALK;
        end
      end
      ST_WALK: begin
        p1_v_nxt = p0_v_r;
        p1_n_nxt = p0_n_r;
        if (hit) begin
          // words reach the compare in visit order, so this is the first match
          res_nxt   = p1_n_r;
          state_nxt = ST_FIN;
        end else if (gen_end_r) begin
          p0_v_nxt = 1'b0;
          if (!p0_v_r && !p1_v_r) begin
            res_nxt   = '0;
            state_nxt = ST_FIN;
          end
        end else begin
          p0_v_nxt = (cand <= NW'(s_r));
          p0_n_nxt = cand[SW-1:0];
          case (k_r)
            PR_SELF: k_nxt = PR_ROW;
            PR_ROW:  k_nxt = PR_COL;
            PR_COL:  k_nxt = PR_DIAG;
            default: begin
              k_nxt = PR_SELF;
              if (c_r == m_r) begin
                c_nxt  = HW'(1);
                cb_nxt = '0;
                if (r_r == m_r) begin
                  gen_end_nxt = 1'b1;
                end else begin
                  r_nxt  = r_r + 1'b1;
                  rb_nxt = rb_r + b_ext;
                end
              end else begin
                c_nxt  = c_r + 1'b1;
                cb_nxt = cb_r + b_ext;
              end
            end
          endcase
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = (res_r != '0);
          out_cell_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      size_used_r <= qrs_pkg::SIZE_CAP;
      gen_end_r   <= 1'b0;
      p0_v_r      <= 1'b0;
      p1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_used_r <= size_used_nxt;
      gen_end_r   <= gen_end_nxt;
      p0_v_r      <= p0_v_nxt;
      p1_v_r      <= p1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s_r         <= s_nxt;
    needle_r    <= needle_nxt;
    b_r         <= b_nxt;
    sq_r        <= sq_nxt;
    m_r         <= m_nxt;
    r_r         <= r_nxt;
    c_r         <= c_nxt;
    k_r         <= k_nxt;
    rb_r        <= rb_nxt;
    cb_r        <= cb_nxt;
    p0_n_r      <= p0_n_nxt;
    p1_n_r      <= p1_n_nxt;
    res_r       <= res_nxt;
    out_found_r <= out_found_nxt;
    out_cell_r  <= out_cell_nxt;
  end

  // cell store: one write port for loads, one registered read for the walk
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_ch.index] <= in_ch.value;
    end
    rd_r <= mem[p0_dec[qrs_pkg::ADDR_W-1:0]];
  end

`ifndef SYNTHESIS
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && hit) |-> (p1_n_r != '0 && p1_n_r <= s_r))
    else $error("match reported outside the searched cells");

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (r_r <= m_r && c_r <= m_r && r_r != '0 && c_r != '0))
    else $error("quadrant counters left the quadrant");

  a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r == (out_cell_r != '0)))
    else $error("found flag disagrees with cell number");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result word loaded outside the finish step");
`endif

endmodule

// File: tb/sv/tb_quadrant_reflection_search.sv
`timescale 1ns / 100ps
// Self-checking bench for quadrant_reflection_search: writes and searches through
// valid/ready channels, first-hit prediction in a scoreboard class, size changes.
// Depends on qrs_pkg and the channel interfaces in qrs_if.sv.

typedef struct packed {
  logic                       found;
  logic [qrs_pkg::SIZE_W-1:0] cell_no;
} hit_t;

class search_scoreboard;
  logic [qrs_pkg::DATA_W-1:0] cells [qrs_pkg::MAX_CELLS];
  logic [qrs_pkg::SIZE_W-1:0] size_used;
  hit_t                       expected_hits [$];
  int                         errors;
  int                         hits_seen;
  int                         misses_seen;

  function new();
    size_used   = qrs_pkg::SIZE_CAP;
    errors      = 0;
    hits_seen   = 0;
    misses_seen = 0;
  endfunction

  // Mirrored quadrant walk: cell, row mirror, column mirror, anti-diagonal.
  function hit_t predict_first_hit(logic [qrs_pkg::DATA_W-1:0] needle);
    int   s;
    int   b;
    int   m;
    int   cand [4];
    hit_t h;
    h = '0;
    s = int'(size_used);
    if (s > qrs_pkg::MAX_CELLS) s = qrs_pkg::MAX_CELLS;
    if (s == 0) return h;
    b = 1;
    while (b * b < s) b++;
    m = (b + 1) / 2;
    for (int r = 1; r <= m; r++) begin
      for (int c = 1; c <= m; c++) begin
        cand[0] = (r - 1) * b + c;
        cand[1] = (r - 1) * b + (b + 1 - c);
        cand[2] = (b - r) * b + c;
        cand[3] = (b - c) * b + (b + 1 - r);
        for (int k = 0; k < 4; k++) begin
          if (cand[k] >= 1 && cand[k] <= s &&
              cells[qrs_pkg::ADDR_W'(cand[k] - 1)] == needle) begin
            h.found   = 1'b1;
            h.cell_no = qrs_pkg::SIZE_W'(cand[k]);
            return h;
          end
        end
      end
    end
    return h;
  endfunction

  function void note_word(logic act, logic [qrs_pkg::ADDR_W-1:0] idx,
                          logic [qrs_pkg::DATA_W-1:0] val);
    if (act == qrs_pkg::ACT_WRITE) cells[idx] = val;
    else expected_hits.push_back(predict_first_hit(val));
  endfunction

  function void check_word(logic found, logic [qrs_pkg::SIZE_W-1:0] cell_no);
    hit_t exp_hit;
    if (expected_hits.size() == 0) begin
      $display("%0t unexpected result word: found=%0b cell=%0d", $time, found, cell_no);
      errors++;
      return;
    end
    exp_hit = expected_hits.pop_front();
    if (found !== exp_hit.found || cell_no !== exp_hit.cell_no) begin
      $display("%0t mismatch: expected found=%0b cell=%0d, got found=%0b cell=%0d",
               $time, exp_hit.found, exp_hit.cell_no, found, cell_no);
      errors++;
    end
    if (exp_hit.found) hits_seen++;
    else misses_seen++;
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction
endclass

module tb_quadrant_reflection_search;

  localparam int   LONG_HOLD     = 400;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   TIMEOUT_NS    = 20_000_000;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  qrs_in_if  in_ch ();
  qrs_out_if out_ch ();
  qrs_cfg_if cfg_ch ();

  quadrant_reflection_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  search_scoreboard sb = new();
  bit               written [qrs_pkg::MAX_CELLS];
  int               burst_left;
  int               hold_req = 0;
  int               long_holds = 0;
  int               n_writes = 0;
  int               n_searches = 0;
  int               n_sizes = 0;
  int               cur_size = qrs_pkg::MAX_CELLS;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_quadrant_reflection_search: done, errors");
    $finish;
  end

  // Receiver: takes result words under a changing stall pattern, plus long holds
  // on request from the stimulus.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       hold_seen;
    int       cyc;
    logic     rdy;
    mode      = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    cyc       = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        sb.check_word(out_ch.found, out_ch.cell_res);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
        long_holds++;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:     rdy = 1'b1;
          RX_COIN:     rdy = 1'($urandom_range(0, 1));
          RX_SPARSE:   rdy = ($urandom_range(0, 7) == 0);
          default:     rdy = (cyc % 5 != 0);
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  function automatic logic [qrs_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0, 1, 2: return qrs_pkg::DATA_W'($urandom_range(0, 7));  // small alphabet -> repeats
      3: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Offers one word and holds it until taken; each burst ends with a gap with valid low.
  task automatic send_word(logic act, logic [qrs_pkg::ADDR_W-1:0] idx,
                           logic [qrs_pkg::DATA_W-1:0] val);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.index  <= idx;
    in_ch.value  <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(act, idx, val);
    if (act == qrs_pkg::ACT_WRITE) begin
      written[idx] = 1'b1;
      n_writes++;
    end else begin
      n_searches++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Drain every pending search, then let the block go quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = $urandom_range(1, 12);
  endtask

  task automatic set_size(int sz);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= qrs_pkg::SIZE_W'(sz);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.size_used = qrs_pkg::SIZE_W'(sz);
    cur_size     = sz;
    n_sizes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Every cell the search may read has to hold a written word.
  task automatic fill_prefix();
    int lim;
    lim = (cur_size > qrs_pkg::MAX_CELLS) ? qrs_pkg::MAX_CELLS : cur_size;
    for (int i = 0; i < lim; i++)
      if (!written[qrs_pkg::ADDR_W'(i)])
        send_word(qrs_pkg::ACT_WRITE, qrs_pkg::ADDR_W'(i), rand_word());
  endtask

  task automatic random_item();
    int                          lim;
    int                          sel;
    logic [qrs_pkg::ADDR_W-1:0]  idx;
    logic [qrs_pkg::DATA_W-1:0]  needle;
    lim = (cur_size > qrs_pkg::MAX_CELLS) ? qrs_pkg::MAX_CELLS : cur_size;
    if ($urandom_range(0, 99) < 35) begin
      if (lim > 0 && $urandom_range(0, 9) < 7)
        idx = qrs_pkg::ADDR_W'($urandom_range(0, lim - 1));
      else idx = qrs_pkg::ADDR_W'($urandom());
      send_word(qrs_pkg::ACT_WRITE, idx, rand_word());
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 60 && lim > 0)
        needle = sb.cells[qrs_pkg::ADDR_W'($urandom_range(0, lim - 1))];
      else if (sel < 75) needle = rand_word();
      else needle = $urandom();
      send_word(qrs_pkg::ACT_SEARCH, qrs_pkg::ADDR_W'($urandom()), needle);
    end
  endtask

  initial begin : stimulus
    int phase_sizes [$];
    in_ch.valid  <= 1'b0;
    in_ch.action <= qrs_pkg::ACT_WRITE;
    in_ch.index  <= '0;
    in_ch.value  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    rst_n        <= 1'b0;
    burst_left = $urandom_range(1, 12);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size zero tests no cell at all
    set_size(0);
    send_word(qrs_pkg::ACT_SEARCH, 10'h3ff, 32'h0000_0000);

    set_size(4);
    send_word(qrs_pkg::ACT_WRITE, 10'd0, 32'h8000_0000);
    send_word(qrs_pkg::ACT_WRITE, 10'd1, 32'h7fff_ffff);
    send_word(qrs_pkg::ACT_WRITE, 10'd2, 32'h0000_0000);
    send_word(qrs_pkg::ACT_WRITE, 10'd3, 32'hffff_ffff);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h8000_0000);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h7fff_ffff);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h0000_0000);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'hffff_ffff);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h1234_5678);
    // word stored past the covered size must stay invisible
    send_word(qrs_pkg::ACT_WRITE, 10'h3ff, 32'h5a5a_a5a5);
    send_word(qrs_pkg::ACT_SEARCH, 10'h155, 32'h5a5a_a5a5);

    set_size(1);
    send_word(qrs_pkg::ACT_SEARCH, 10'h2aa, 32'h8000_0000);
    send_word(qrs_pkg::ACT_SEARCH, 10'h0, 32'h7fff_ffff);

    // b=3: mirrors of the quadrant fall past size 5 and get skipped
    set_size(5);
    send_word(qrs_pkg::ACT_WRITE, 10'd4, 32'h7fff_ffff);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h7fff_ffff);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'hffff_ffff);

    phase_sizes = '{1, 2, 3, 4, 7, 9, 16, 17, 25, 36, 50, 64, 100, 200};
    repeat (3) phase_sizes.push_back($urandom_range(1, 128));
    foreach (phase_sizes[p]) begin
      set_size(phase_sizes[p]);
      fill_prefix();
      if (p == 5 || p == 11) hold_req <= hold_req + 1;
      repeat (20) random_item();
    end

    // full and oversize settings: only cells 1 and 32 are probed before the hit,
    // both written; a clamped size gives side 32, so the row mirror of cell 1 is 32
    send_word(qrs_pkg::ACT_WRITE, 10'd0, 32'h1357_9bdf);
    send_word(qrs_pkg::ACT_WRITE, 10'd31, 32'h2468_ace0);
    set_size(qrs_pkg::MAX_CELLS);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h1357_9bdf);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h2468_ace0);
    set_size(2047);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h1357_9bdf);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h2468_ace0);
    set_size(1025);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h1357_9bdf);
    send_word(qrs_pkg::ACT_SEARCH, 10'd0, 32'h2468_ace0);

    settle();
    $display("summary: %0d writes, %0d searches (%0d hits, %0d misses), %0d size settings",
             n_writes, n_searches, sb.hits_seen, sb.misses_seen, n_sizes);
    $display("summary: sizes 0 through 2047 incl. clamp, %0d long output holds, %0d errors",
             long_holds, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_quadrant_reflection_search: done, clean");
    end else begin
      $display("tb_quadrant_reflection_search: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_if.sv
hw/rtl/quadrant_reflection_search.sv
tb/sv/tb_quadrant_reflection_search.sv
